// ===== rtl/indexed_shift_list_defines.svh =====
// ----------------------------------------------------------------------------
// indexed_shift_list_defines.svh
// Assertion macros for the ordered list RTL (indexed_shift_list).
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_DEFINES_SVH
`define INDEXED_SHIFT_LIST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISL_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_shift_list: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ISL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_shift_list: next-cycle check failed");

`endif

// ===== rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Action codes and the per-item control group broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  localparam int ACTION_W = 3;

  localparam logic [ACTION_W-1:0] ACT_APPEND  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_GET     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REPLACE = 3'd4;

  // At most one flag is set, and only for an accepted item that succeeds.
  typedef struct packed {
    logic append;
    logic insert;
    logic remove;
    logic get;
    logic replace;
  } isl_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: holds a word and takes item_in or a neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_cell #(
  parameter int POS    = 0,
  parameter int IDX_W  = 5,
  parameter int ITEM_W = 32
) (
  input  wire                    clk,
  input  isl_pkg::isl_ctl_t      ctl_i,
  input  wire  [IDX_W-1:0]       idx_i,
  input  wire  [IDX_W-1:0]       count_i,
  input  wire  [ITEM_W-1:0]      item_i,
  input  wire  [ITEM_W-1:0]      lo_i,    // word of slot POS-1
  input  wire  [ITEM_W-1:0]      hi_i,    // word of slot POS+1
  output logic [ITEM_W-1:0]      word_o,
  output logic [ITEM_W-1:0]      rd_o     // word when this slot is read, else zero
);
  import isl_pkg::*;

  localparam logic [IDX_W-1:0] POS_C  = IDX_W'(POS);
  localparam logic [IDX_W-1:0] POS_P1 = IDX_W'(POS + 1);

  logic [ITEM_W-1:0] word_r;
  logic [ITEM_W-1:0] word_nxt;
  logic              at_idx;
  logic              load;
  logic              from_lo;
  logic              from_hi;

  always_comb begin
    at_idx  = (POS_C == idx_i);
    load    = (ctl_i.append && (POS_C == count_i)) ||
              ((ctl_i.insert || ctl_i.replace) && at_idx);
    // insert: slots idx+1..count move up
    from_lo = ctl_i.insert && (POS_C > idx_i) && (POS_C <= count_i);
    // remove: slots idx..count-2 move down
    from_hi = ctl_i.remove && (POS_C >= idx_i) && (POS_P1 < count_i);
    if (load) begin
      word_nxt = item_i;
    end else if (from_lo) begin
      word_nxt = lo_i;
    end else if (from_hi) begin
      word_nxt = hi_i;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  assign rd_o   = (ctl_i.get && at_idx) ? word_r : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_shift_list.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list of item words with append, insert, remove, get and replace.
// ----------------------------------------------------------------------------
// The list is a row of DEPTH slot cells plus a length register. Every
// accepted item is done in the cycle it is accepted: on insert each slot
// above the index loads from the slot below it, on remove each slot from the
// index up loads from the slot above it, all slots at once. So the block
// takes one item per clock while in_ready is high, and its result appears in
// the output register in the next cycle. in_ready is low during reset; after
// that it stays high while the output register is empty or being drained, so
// a held result costs no throughput once out_ready rises.
// A failed item (index out of range, list full, unknown action) leaves the
// list untouched and returns ok = 0 with item_out = 0. length and is_empty
// always report the list after the item. Slot contents are not cleared at
// reset; only slots below length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_shift_list_defines.svh"

module indexed_shift_list #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH + 1)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // request channel
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [isl_pkg::ACTION_W-1:0]   in_action,
  input  wire  [IDX_W-1:0]               in_index,
  input  wire  [ITEM_WIDTH-1:0]          in_item_in,
  // result channel
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_ok,
  output logic [ITEM_WIDTH-1:0]          out_item_out,
  output logic [IDX_W-1:0]               out_length,
  output logic                           out_is_empty
);
  import isl_pkg::*;

  localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(DEPTH);

  logic                  in_fire;
  logic                  full;
  isl_ctl_t              ctl;
  logic                  ok;

  logic [IDX_W-1:0]      count_r;
  logic [IDX_W-1:0]      count_nxt;

  logic [ITEM_WIDTH-1:0] words [DEPTH];
  logic [ITEM_WIDTH-1:0] rds   [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_word;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [ITEM_WIDTH-1:0] out_item_out_r;
  logic [IDX_W-1:0]      out_length_r;
  logic                  out_is_empty_r;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == DEPTH_C);

  // decode: a flag is set only when the item is accepted and in range
  always_comb begin
    ctl = '0;
    case (in_action)
      ACT_APPEND:  ctl.append  = in_fire && !full;
      ACT_INSERT:  ctl.insert  = in_fire && !full && (in_index <= count_r);
      ACT_REMOVE:  ctl.remove  = in_fire && (in_index < count_r);
      ACT_GET:     ctl.get     = in_fire && (in_index < count_r);
      ACT_REPLACE: ctl.replace = in_fire && (in_index < count_r);
      default:     ctl = '0;
    endcase
    ok = |ctl;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.append || ctl.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // slot row; the ends see zero as their missing neighbor
  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    logic [ITEM_WIDTH-1:0] lo_w;
    logic [ITEM_WIDTH-1:0] hi_w;

    if (p == 0) begin : g_lo_end
      assign lo_w = '0;
    end else begin : g_lo
      assign lo_w = words[p-1];
    end
    if (p == DEPTH - 1) begin : g_hi_end
      assign hi_w = '0;
    end else begin : g_hi
      assign hi_w = words[p+1];
    end

    isl_cell #(
      .POS    (p),
      .IDX_W  (IDX_W),
      .ITEM_W (ITEM_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .idx_i   (in_index),
      .count_i (count_r),
      .item_i  (in_item_in),
      .lo_i    (lo_w),
      .hi_i    (hi_w),
      .word_o  (words[p]),
      .rd_o    (rds[p])
    );
  end

  // at most one cell drives a nonzero read word
  always_comb begin
    rd_word = '0;
    for (int p = 0; p < DEPTH; p++) begin
      rd_word = rd_word | rds[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ok_r       <= ok;
      out_item_out_r <= rd_word;
      out_length_r   <= count_nxt;
      out_is_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_item_out = out_item_out_r;
  assign out_length   = out_length_r;
  assign out_is_empty = out_is_empty_r;

  `ISL_ASSERT(a_count_range, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `ISL_ASSERT(a_ctl_onehot, clk, rst_n, 1'b1, $onehot0(ctl))
  `ISL_ASSERT(a_len_tracks, clk, rst_n, out_valid_r, out_length_r == count_r)
  `ISL_ASSERT_NEXT(a_fire_result, clk, rst_n, in_fire, out_valid_r)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed shift list.
// ----------------------------------------------------------------------------
// A table of directed requests runs first. It covers the empty list, the
// lowest and highest unused action codes, a fill to full and the refusals at
// full. Random requests follow. They swing the list between empty and full,
// with a few out-of-range indexes and unused codes mixed in. Each accepted
// request goes through a shadow copy of the list, and the result that copy
// gives is queued. Every result the block returns is compared field by field
// with the oldest queued one. Both sides of the handshake stall at random,
// and the rate of stalling changes with each phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import isl_pkg::*;

  localparam int DEPTH        = 16;
  localparam int ITEM_W       = 32;
  localparam int IDX_W        = 5;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 48;    // long receiver stall, fills the block
  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 4;

  // codes the action field can carry but the block does not implement
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACT_REPLACE + 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TOP       = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [ITEM_W-1:0] item;
    logic [IDX_W-1:0]  len;
    logic              empty;
  } list_result_t;

  // one table row; typed rows carry the result that can be read at a glance
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    index;
    logic [ITEM_W-1:0]   word;
    logic [5:0]          reps;
    logic                typed;
    list_result_t        exp;
  } req_row_t;

  localparam int DIR_ROWS = 23;

  req_row_t dir_table [DIR_ROWS] = '{
    // empty list: everything but append and insert at 0 is refused
    '{ACT_GET,       5'd0,  32'h0,         6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    '{ACT_REMOVE,    5'd0,  32'h0,         6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    '{ACT_REPLACE,   5'd0,  32'hDEAD_BEEF, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    '{ACT_INSERT,    5'd1,  32'h1111_1111, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    '{ACT_UNUSED_LO, 5'd0,  32'hFFFF_FFFF, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    '{ACT_TOP,       5'd31, 32'hFFFF_FFFF, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd0, 1'b1}},
    // first entries, all-ones and all-zeros words
    '{ACT_INSERT,    5'd0,  32'hFFFF_FFFF, 6'd1,  1'b1, '{1'b1, 32'h0, 5'd1, 1'b0}},
    '{ACT_APPEND,    5'd31, 32'h0,         6'd1,  1'b1, '{1'b1, 32'h0, 5'd2, 1'b0}},
    '{ACT_GET,       5'd0,  32'h0,         6'd1,  1'b1,
      '{1'b1, 32'hFFFF_FFFF, 5'd2, 1'b0}},
    // mid insert, insert at count (append), remove head, replace, far index
    '{ACT_INSERT,    5'd1,  32'h1234_5678, 6'd1,  1'b0, '0},
    '{ACT_INSERT,    5'd3,  32'hA5A5_A5A5, 6'd1,  1'b0, '0},
    '{ACT_REMOVE,    5'd0,  32'h0,         6'd1,  1'b0, '0},
    '{ACT_REPLACE,   5'd2,  32'h5A5A_5A5A, 6'd1,  1'b0, '0},
    '{ACT_GET,       5'd31, 32'h0,         6'd1,  1'b0, '0},
    // fill to the top, then knock on a full list
    '{ACT_APPEND,    5'd0,  32'hC0DE_0000, 6'd13, 1'b0, '0},
    '{ACT_APPEND,    5'd0,  32'h7777_7777, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd16, 1'b0}},
    '{ACT_INSERT,    5'd0,  32'h7777_7777, 6'd1,  1'b1, '{1'b0, 32'h0, 5'd16, 1'b0}},
    '{ACT_GET,       5'd15, 32'h0,         6'd1,  1'b0, '0},
    '{ACT_GET,       5'd16, 32'h0,         6'd1,  1'b1, '{1'b0, 32'h0, 5'd16, 1'b0}},
    '{ACT_REPLACE,   5'd15, 32'h0,         6'd1,  1'b0, '0},
    // top slot out and back in, then the head
    '{ACT_REMOVE,    5'd15, 32'h0,         6'd1,  1'b0, '0},
    '{ACT_INSERT,    5'd15, 32'h8000_0001, 6'd1,  1'b0, '0},
    '{ACT_REMOVE,    5'd0,  32'h0,         6'd1,  1'b0, '0}
  };

  // per-phase stall rates, in percent of cycles
  int send_idle_by_phase [3] = '{37, 85, 0};
  int recv_idle_by_phase [3] = '{85, 37, 0};

  logic clk = 1'b0;
  logic rst_n;

  logic                in_valid;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action;
  logic [IDX_W-1:0]    in_index;
  logic [ITEM_W-1:0]   in_item_in;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_ok;
  logic [ITEM_W-1:0]   out_item_out;
  logic [IDX_W-1:0]    out_length;
  logic                out_is_empty;

  // side band that travels with the payload: a typed expectation, if any
  logic                drv_typed;
  list_result_t        drv_exp;

  // shadow copy of the list
  logic [ITEM_W-1:0] shadow_words [DEPTH];
  int                shadow_len = 0;
  bit                growing = 1'b1;

  list_result_t results_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_req   = 0;
  int holdoff_seen  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int errors        = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int ok_count      = 0;
  int fills         = 0;
  int drains        = 0;
  int full_refusals = 0;

  indexed_shift_list dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_index     (in_index),
    .in_item_in   (in_item_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_item_out (out_item_out),
    .out_length   (out_length),
    .out_is_empty (out_is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the result it gives.
  // Insert and remove shift the whole tail, the way the slot row does.
  function automatic list_result_t apply_request(logic [ACTION_W-1:0] act,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [ITEM_W-1:0] word);
    list_result_t r;
    int           pos;
    int           at;
    r  = '0;
    at = int'(idx);
    case (act)
      ACT_APPEND: begin
        if (shadow_len < DEPTH) begin
          shadow_words[shadow_len] = word;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (at <= shadow_len && shadow_len < DEPTH) begin
          for (pos = shadow_len; pos > at; pos--) shadow_words[pos] = shadow_words[pos - 1];
          shadow_words[at] = word;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (at < shadow_len) begin
          for (pos = at; pos + 1 < shadow_len; pos++) shadow_words[pos] = shadow_words[pos + 1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (at < shadow_len) begin
          r.item = shadow_words[at];
          r.ok   = 1'b1;
        end
      end
      ACT_REPLACE: begin
        if (at < shadow_len) begin
          shadow_words[at] = word;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.len   = IDX_W'(shadow_len);
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic check_field(string fld, logic [ITEM_W-1:0] want, logic [ITEM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fld, want, got);
      errors++;
    end
  endtask

  // Offer one request, with random gaps before it, and hold it until taken.
  // Returns at the falling edge after acceptance.
  task automatic send_request(logic [ACTION_W-1:0] act, logic [IDX_W-1:0] idx,
                              logic [ITEM_W-1:0] word, logic typed, list_result_t exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_index   <= idx;
    in_item_in <= word;
    drv_typed  <= typed;
    drv_exp    <= exp;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request that steers the list between empty and full: while
  // growing, appends and inserts dominate, and removes once the top is hit.
  // About one in ten indexes is drawn from the whole field, mostly out of range.
  task automatic random_request(output logic [ACTION_W-1:0] act,
                                output logic [IDX_W-1:0] idx,
                                output logic [ITEM_W-1:0] word);
    int pick;
    if (shadow_len == DEPTH) growing = 1'b0;
    else if (shadow_len == 0) growing = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      act = ACTION_W'($urandom_range(ACT_TOP, ACT_UNUSED_LO));
    end else begin
      pick = $urandom_range(0, 99);
      if (growing)
        act = pick < 30 ? ACT_APPEND : pick < 55 ? ACT_INSERT : pick < 68 ? ACT_REMOVE :
              pick < 84 ? ACT_GET : ACT_REPLACE;
      else
        act = pick < 10 ? ACT_APPEND : pick < 20 ? ACT_INSERT : pick < 60 ? ACT_REMOVE :
              pick < 80 ? ACT_GET : ACT_REPLACE;
    end
    if ($urandom_range(0, 9) == 0)
      idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    else if (act == ACT_INSERT)
      idx = IDX_W'($urandom_range(0, shadow_len));
    else if (shadow_len == 0)
      idx = '0;
    else
      idx = IDX_W'($urandom_range(0, shadow_len - 1));
    word = $urandom;
  endtask

  // Receiver: a requested hold-off wins, otherwise stall at the phase rate.
  always @(negedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      hold_left    = HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Sample both channels at the rising edge. The result is handled before the
  // request: a request's result never comes out in the edge it is taken.
  always @(posedge clk) begin : result_check
    list_result_t want;
    bit           moved;
    if (rst_n === 1'b1) begin
      moved = 1'b0;
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        moved = 1'b1;
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result arrived with nothing outstanding");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("ok",       ITEM_W'(want.ok),    ITEM_W'(out_ok));
          check_field("item_out", want.item,           out_item_out);
          check_field("length",   ITEM_W'(want.len),   ITEM_W'(out_length));
          check_field("is_empty", ITEM_W'(want.empty), ITEM_W'(out_is_empty));
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        moved = 1'b1;
        requests_sent++;
        want = apply_request(in_action, in_index, in_item_in);
        if (drv_typed) want = drv_exp;
        if (want.ok) ok_count++;
        if (want.ok && want.len == DEPTH && (in_action == ACT_APPEND || in_action == ACT_INSERT))
          fills++;
        if (!want.ok && want.len == DEPTH && (in_action == ACT_APPEND || in_action == ACT_INSERT))
          full_refusals++;
        if (want.ok && want.empty && in_action == ACT_REMOVE)
          drains++;
        results_due.push_back(want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: a hung handshake ends the run.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $error("no handshake for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ACTION_W-1:0] act;
    logic [IDX_W-1:0]    idx;
    logic [ITEM_W-1:0]   word;
    int                  ph;
    int                  n;
    int                  k;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_action  = ACT_APPEND;
    in_index   = '0;
    in_item_in = '0;
    drv_typed  = 1'b0;
    drv_exp    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = send_idle_by_phase[0];
    recv_idle_pct = recv_idle_by_phase[0];

    // directed table
    foreach (dir_table[r]) begin
      for (k = 0; k < int'(dir_table[r].reps); k++)
        send_request(dir_table[r].action, dir_table[r].index,
                     dir_table[r].word + ITEM_W'(k), dir_table[r].typed, dir_table[r].exp);
    end

    // random phases
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      recv_idle_pct = recv_idle_by_phase[ph];
      // long receiver stall while requests keep coming
      if (ph != 1) holdoff_req++;
      for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
        random_request(act, idx, word);
        send_request(act, idx, word, 1'b0, '0);
      end
      // sender waits out every outstanding result once
      if (ph == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due.size() != 0) @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d succeeded",
             requests_sent, results_seen, ok_count);
    $display("list filled %0d times, refused %0d times at full, drained to empty %0d times",
             fills, full_refusals, drains);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== indexed_shift_list.f =====
+incdir+rtl
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_shift_list.sv
verif/tb.sv
